/* sv/sbsd_pkg.sv */
package sbsd_pkg;

   localparam int HitW     = 15;
   localparam int BitThrW  = 10;
   localparam int SpbW     = 10;
   localparam int SyncW    = 4;
   localparam int PreW     = 5;
   localparam int MsgW     = 12;
   localparam int RunW     = 5;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 15;

   // register indexes of the configuration port
   localparam logic [CsrIdxW-1:0] CSR_HIT_LEVEL       = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_BIT_LEVEL       = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_SAMPLES_PER_BIT = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_SYNC_EDGES      = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_PREAMBLE_BITS   = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_MESSAGE_BYTES   = 3'd5;

   localparam logic [HitW-1:0]    HIT_LEVEL_RST       = 15'd6;
   localparam logic [BitThrW-1:0] BIT_LEVEL_RST       = 10'd50;
   localparam logic [SpbW-1:0]    SAMPLES_PER_BIT_RST = 10'd100;
   localparam logic [SyncW-1:0]   SYNC_EDGES_RST      = 4'd5;
   localparam logic [PreW-1:0]    PREAMBLE_BITS_RST   = 5'd10;
   localparam logic [MsgW-1:0]    MESSAGE_BYTES_RST   = 12'd240;

   typedef struct packed {
      logic [HitW-1:0]    hit_level;
      logic [BitThrW-1:0] bit_level;
      logic [SpbW-1:0]    samples_per_bit;
      logic [SyncW-1:0]   sync_edges;
      logic [PreW-1:0]    preamble_bits;
      logic [MsgW-1:0]    message_bytes;
   } cfg_type;

   // what the slicer hands to the deframer for the item it retires
   typedef struct packed {
      logic step;       // an item leaves the input register this cycle
      logic bit_done;   // that item closes a bit window
      logic bit_value;  // sliced bit of the closed window
   } bit_event_type;

endpackage

/* sv/sbsd_csr.sv */
module sbsd_csr
   import sbsd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_en,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata,
   output cfg_type             cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_HIT_LEVEL:       cfg_in.hit_level       = csr_wdata[HitW-1:0];
            CSR_BIT_LEVEL:       cfg_in.bit_level       = csr_wdata[BitThrW-1:0];
            CSR_SAMPLES_PER_BIT: cfg_in.samples_per_bit = csr_wdata[SpbW-1:0];
            CSR_SYNC_EDGES:      cfg_in.sync_edges      = csr_wdata[SyncW-1:0];
            CSR_PREAMBLE_BITS:   cfg_in.preamble_bits   = csr_wdata[PreW-1:0];
            CSR_MESSAGE_BYTES:   cfg_in.message_bytes   = csr_wdata[MsgW-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hit_level       <= HIT_LEVEL_RST;
         cfg_ff.bit_level       <= BIT_LEVEL_RST;
         cfg_ff.samples_per_bit <= SAMPLES_PER_BIT_RST;
         cfg_ff.sync_edges      <= SYNC_EDGES_RST;
         cfg_ff.preamble_bits   <= PREAMBLE_BITS_RST;
         cfg_ff.message_bytes   <= MESSAGE_BYTES_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* sv/sbsd_slicer.sv */
module sbsd_slicer
   import sbsd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic            req_probe_missed,
   input  logic [HitW-1:0] req_probe_count,
   input  logic            out_free,
   output bit_event_type   bit_event
);

   logic            in_valid_ff, in_valid_in;
   logic            in_missed_ff;
   logic [HitW-1:0] in_count_ff;
   logic [SpbW-1:0] sample_index_ff, sample_index_in;
   logic [SpbW-1:0] hit_total_ff, hit_total_in;

   logic            accept;
   logic            step;
   logic            hit;
   logic [SpbW-1:0] hit_total_next;
   logic [SpbW-1:0] index_next;
   logic [SpbW-1:0] window;
   logic            close;

   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign hit            = !in_missed_ff && (in_count_ff >= cfg.hit_level);
   assign hit_total_next = hit_total_ff + {{(SpbW-1){1'b0}}, hit};
   assign index_next     = sample_index_ff + {{(SpbW-1){1'b0}}, 1'b1};
   // a zero window length behaves as one sample per bit
   assign window = (cfg.samples_per_bit == '0) ? {{(SpbW-1){1'b0}}, 1'b1}
                                               : cfg.samples_per_bit;
   assign close  = (index_next == '0) || (index_next >= window);

   always_comb begin
      in_valid_in     = in_valid_ff;
      sample_index_in = sample_index_ff;
      hit_total_in    = hit_total_ff;
      if (step) begin
         in_valid_in = 1'b0;
         if (close) begin
            sample_index_in = '0;
            hit_total_in    = '0;
         end else begin
            sample_index_in = index_next;
            hit_total_in    = hit_total_next;
         end
      end
      if (accept) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         sample_index_ff <= '0;
         hit_total_ff    <= '0;
      end else begin
         in_valid_ff     <= in_valid_in;
         sample_index_ff <= sample_index_in;
         hit_total_ff    <= hit_total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_missed_ff <= req_probe_missed;
         in_count_ff  <= req_probe_count;
      end
   end

   assign bit_event.step      = step;
   assign bit_event.bit_done  = close;
   assign bit_event.bit_value = hit_total_next > cfg.bit_level;

endmodule

/* sv/sbsd_deframer.sv */
module sbsd_deframer
   import sbsd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  bit_event_type bit_event,
   output logic          out_free,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [7:0]    rsp_data_byte,
   output logic          rsp_last_byte
);

   typedef enum logic [1:0] {
      PH_SYNC,
      PH_PREAMBLE,
      PH_DATA
   } phase_type;

   typedef enum logic [1:0] {
      PREV_ZERO,
      PREV_ONE,
      PREV_NONE
   } prev_type;

   localparam logic [RunW-1:0] RunMax = '1;

   phase_type       phase_ff, phase_in;
   prev_type        prev_bit_ff, prev_bit_in;
   logic [RunW-1:0] run_count_ff, run_count_in;
   logic [2:0]      bit_pos_ff, bit_pos_in;
   logic [7:0]      byte_shift_ff, byte_shift_in;
   logic [MsgW-1:0] bytes_done_ff, bytes_done_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      data_byte_ff, data_byte_in;
   logic            last_byte_ff, last_byte_in;

   logic            bit_value;
   logic [RunW-1:0] run_tmp;
   logic [7:0]      shift_tmp;
   logic [MsgW-1:0] bytes_tmp;
   logic            is_last;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign bit_value = bit_event.bit_value;

   always_comb begin
      phase_in      = phase_ff;
      prev_bit_in   = prev_bit_ff;
      run_count_in  = run_count_ff;
      bit_pos_in    = bit_pos_ff;
      byte_shift_in = byte_shift_ff;
      bytes_done_in = bytes_done_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      data_byte_in  = data_byte_ff;
      last_byte_in  = last_byte_ff;
      run_tmp       = run_count_ff;
      shift_tmp     = byte_shift_ff | ({7'd0, bit_value} << bit_pos_ff);
      bytes_tmp     = bytes_done_ff + {{(MsgW-1){1'b0}}, 1'b1};
      is_last       = (bytes_tmp == cfg.message_bytes);

      if (bit_event.step && bit_event.bit_done) begin
         unique case (phase_ff)
            PH_SYNC: begin
               if (prev_bit_ff == PREV_ZERO && bit_value) begin
                  run_tmp = (run_count_ff == RunMax) ? RunMax : run_count_ff + 1'b1;
               end else if ((prev_bit_ff == PREV_ZERO && !bit_value) ||
                            (prev_bit_ff == PREV_ONE && bit_value)) begin
                  run_tmp = '0;
               end
               prev_bit_in = bit_value ? PREV_ONE : PREV_ZERO;
               if (run_tmp >= {1'b0, cfg.sync_edges}) begin
                  phase_in     = PH_PREAMBLE;
                  run_count_in = '0;
               end else begin
                  run_count_in = run_tmp;
               end
            end
            PH_PREAMBLE: begin
               if (bit_value) begin
                  run_tmp = (run_count_ff == RunMax) ? RunMax : run_count_ff + 1'b1;
               end else begin
                  run_tmp = '0;
               end
               if (run_tmp >= cfg.preamble_bits) begin
                  phase_in      = PH_DATA;
                  run_count_in  = '0;
                  bit_pos_in    = '0;
                  byte_shift_in = '0;
                  bytes_done_in = '0;
               end else begin
                  run_count_in = run_tmp;
               end
            end
            PH_DATA: begin
               bit_pos_in = bit_pos_ff + 3'd1;
               if (bit_pos_ff == 3'd7) begin
                  // byte complete: load the result register
                  rsp_valid_in  = 1'b1;
                  data_byte_in  = shift_tmp;
                  last_byte_in  = is_last;
                  byte_shift_in = '0;
                  if (is_last) begin
                     bytes_done_in = '0;
                     phase_in      = PH_SYNC;
                     prev_bit_in   = PREV_NONE;
                     run_count_in  = '0;
                  end else begin
                     bytes_done_in = bytes_tmp;
                  end
               end else begin
                  byte_shift_in = shift_tmp;
               end
            end
            default: begin
               phase_in     = PH_SYNC;
               prev_bit_in  = PREV_NONE;
               run_count_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SYNC;
         prev_bit_ff   <= PREV_NONE;
         run_count_ff  <= '0;
         bit_pos_ff    <= '0;
         byte_shift_ff <= '0;
         bytes_done_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         prev_bit_ff   <= prev_bit_in;
         run_count_ff  <= run_count_in;
         bit_pos_ff    <= bit_pos_in;
         byte_shift_ff <= byte_shift_in;
         bytes_done_ff <= bytes_done_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      data_byte_ff <= data_byte_in;
      last_byte_ff <= last_byte_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data_byte = data_byte_ff;
   assign rsp_last_byte = last_byte_ff;

endmodule

/* sv/sample_bit_slicer_deframer.sv */
// Probe sample bit slicer and deframer. One sample is taken per clock when
// req_stall is low; a sample passes from the input register through the
// hit compare, window counter and sync/preamble/data state logic into the
// result register, so rsp_valid rises at the edge at which the sample that
// completes a byte leaves the input register. The sustained rate is one
// sample per clock while no byte waits under rsp_stall. Only rsp_stall slows
// the input: req_stall rises when a sample sits in the input register while
// a byte waits in the result register with rsp_stall high. A byte is
// produced only when eight data bits have completed; rsp_last_byte marks the
// message_bytes-th byte, after which the block hunts for sync again. Bit
// windows run continuously across phase changes. Write configuration
// registers only while the block is idle.
module sample_bit_slicer_deframer
   import sbsd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_en,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_probe_missed,
   input  logic [HitW-1:0]     req_probe_count,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_data_byte,
   output logic                rsp_last_byte
);

   cfg_type       cfg;
   bit_event_type bit_event;
   logic          out_free;

   sbsd_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   sbsd_slicer u_slicer (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_probe_missed (req_probe_missed),
      .req_probe_count  (req_probe_count),
      .out_free         (out_free),
      .bit_event        (bit_event)
   );

   sbsd_deframer u_deframer (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .bit_event     (bit_event),
      .out_free      (out_free),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data_byte (rsp_data_byte),
      .rsp_last_byte (rsp_last_byte)
   );

endmodule
